// File: rtl/rcps_pkg.sv
// Shared types and constants for the ring centroid / polar shape block.
// Depends on nothing; used by ring_centroid_polar_shape_top.
package rcps_pkg;

  localparam int SUM_W = 38;   // running sum width, 64 nodes of 32 bits
  localparam int CORDIC_W = 36; // CORDIC x/y width, covers gain and pre-rotation
  localparam int ITER_N = 32;

  localparam logic [1:0] REG_CELL_XX = 2'd0;
  localparam logic [1:0] REG_CELL_XY = 2'd1;
  localparam logic [1:0] REG_CELL_YX = 2'd2;
  localparam logic [1:0] REG_CELL_YY = 2'd3;

  localparam logic [31:0] ANGLE_ZERO = 32'h0000_0000;
  localparam logic [31:0] ANGLE_QUARTER = 32'h4000_0000;
  localparam logic [31:0] ANGLE_HALF = 32'h8000_0000;
  localparam logic [31:0] ANGLE_3QUARTER = 32'hC000_0000;

  typedef struct packed {
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic               is_last_node;
  } item_t;

  typedef struct packed {
    logic [5:0]         node_index;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic [31:0]        radius;
    logic [31:0]        polar_angle;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               is_last_result;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL,
    S_READ,
    S_DIFF,
    S_ITER,
    S_EMIT
  } state_t;

  // arctangent of 2^-i as a fraction of a full turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ring_centroid_polar_shape_top.sv
// Ring centroid and polar shape: node store, centroid divider, shared
// multiplier, square root and CORDIC sequencer. Depends on rcps_pkg.
//
// A node beat (start high while busy low) is stored and summed; busy stays
// low between nodes. The beat with is_last_node set starts a run: a setup
// state, centroid division at one bit per cycle, the shared multiplier for
// the transformed centroid, then for each stored node a memory read, the
// offset, multiplier slots for the matrix and the two squares, 32 steps of
// square root and CORDIC run side by side, and a result state. Each result
// sits on result for exactly one cycle with strobe high; there is no
// backpressure, the receiver must take every beat. Nodes beyond MAX_NODES
// are dropped but a last mark on them still starts the run. Cell registers
// are written through cfg_* while the block is idle (cfg_ready).
module ring_centroid_polar_shape_top #(
  parameter int MAX_NODES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  rcps_pkg::item_t        item,
  output logic                   strobe,
  output rcps_pkg::result_t      result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = rcps_pkg::SUM_W;
  localparam int XW = rcps_pkg::CORDIC_W;

  rcps_pkg::state_t state, state_next;

  // cell matrix
  logic signed [31:0] cell_xx, cell_xy, cell_yx, cell_yy;

  // node store, x and y side by side
  logic [63:0] mem [MAX_NODES];
  logic [63:0] rd_data;

  logic signed [SW-1:0] sum_x, sum_y;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [5:0] cnt;

  // centroid divider
  logic [SW-1:0] qx, qy;
  logic [CW-1:0] rem_x, rem_y;
  logic neg_x, neg_y;
  logic signed [31:0] cent_x, cent_y;

  // multiplier and products
  logic signed [32:0] mul_a, mul_b, dx, dy;
  logic signed [65:0] prod, p_hold;
  logic signed [31:0] dot_sat, rx, ry, tcx, tcy;
  logic center_pass;

  // square root
  logic [63:0] sq_v;
  logic [33:0] sq_r;
  logic [31:0] sq_q;

  // CORDIC
  logic signed [XW-1:0] cx_c, cy_c;
  logic [31:0] z;
  logic spec;
  logic [31:0] spec_val;
  logic last_node;

  logic accept, cfg_we;

  always_comb begin
    busy = (state != rcps_pkg::S_IDLE);
    cfg_ready = (state == rcps_pkg::S_IDLE);
    strobe = (state == rcps_pkg::S_EMIT);
  end

  assign accept = start && !busy;
  assign cfg_we = cfg_valid && cfg_ready;
  assign last_node = (idx == AW'(count - CW'(1)));

  always_comb begin
    state_next = state;
    case (state)
      rcps_pkg::S_IDLE: if (accept && item.is_last_node) state_next = rcps_pkg::S_PREP;
      rcps_pkg::S_PREP: state_next = rcps_pkg::S_DIV;
      rcps_pkg::S_DIV:  if (cnt == 6'(SW - 1)) state_next = rcps_pkg::S_MUL;
      rcps_pkg::S_MUL: begin
        if (center_pass && cnt == 6'd4) state_next = rcps_pkg::S_READ;
        else if (!center_pass && cnt == 6'd7) state_next = rcps_pkg::S_ITER;
      end
      rcps_pkg::S_READ: state_next = rcps_pkg::S_DIFF;
      rcps_pkg::S_DIFF: state_next = rcps_pkg::S_MUL;
      rcps_pkg::S_ITER: if (cnt == 6'(rcps_pkg::ITER_N - 1)) state_next = rcps_pkg::S_EMIT;
      rcps_pkg::S_EMIT: state_next = last_node ? rcps_pkg::S_IDLE : rcps_pkg::S_READ;
      default: state_next = rcps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcps_pkg::S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= (state_next != state) ? 6'd0 : cnt + 6'd1;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_xx <= 32'sd65536;
      cell_xy <= '0;
      cell_yx <= '0;
      cell_yy <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        rcps_pkg::REG_CELL_XX: cell_xx <= cfg_data;
        rcps_pkg::REG_CELL_XY: cell_xy <= cfg_data;
        rcps_pkg::REG_CELL_YX: cell_yx <= cfg_data;
        rcps_pkg::REG_CELL_YY: cell_yy <= cfg_data;
        default: ;
      endcase
    end
  end

  // node store: written while loading, read once per node during a run
  always_ff @(posedge clk) begin
    if (accept && count < CW'(MAX_NODES)) mem[count[AW-1:0]] <= {item.node_x, item.node_y};
    if (state == rcps_pkg::S_READ) rd_data <= mem[idx];
  end

  // sums and count; cleared when the last result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (accept && count < CW'(MAX_NODES)) begin
      sum_x <= sum_x + SW'(item.node_x);
      sum_y <= sum_y + SW'(item.node_y);
      count <= count + CW'(1);
    end else if (state == rcps_pkg::S_EMIT && last_node) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end
  end

  // restoring divide of |sum| by count, quotient shifts into q
  logic [CW:0] tx, ty;
  assign tx = {rem_x, qx[SW-1]};
  assign ty = {rem_y, qy[SW-1]};

  always_ff @(posedge clk) begin
    if (state == rcps_pkg::S_PREP) begin
      neg_x <= sum_x[SW-1];
      neg_y <= sum_y[SW-1];
      qx <= sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
      qy <= sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
      rem_x <= '0;
      rem_y <= '0;
    end else if (state == rcps_pkg::S_DIV) begin
      if (tx >= {1'b0, count}) begin
        rem_x <= CW'(tx - {1'b0, count});
        qx <= {qx[SW-2:0], 1'b1};
      end else begin
        rem_x <= CW'(tx);
        qx <= {qx[SW-2:0], 1'b0};
      end
      if (ty >= {1'b0, count}) begin
        rem_y <= CW'(ty - {1'b0, count});
        qy <= {qy[SW-2:0], 1'b1};
      end else begin
        rem_y <= CW'(ty);
        qy <= {qy[SW-2:0], 1'b0};
      end
    end
  end

  assign cent_x = neg_x ? 32'(-qx) : 32'(qx);
  assign cent_y = neg_y ? 32'(-qy) : 32'(qy);

  // shared multiplier: slots 0..3 matrix, 5..6 squares
  always_comb begin
    logic signed [32:0] va, vb;
    va = center_pass ? 33'(cent_x) : dx;
    vb = center_pass ? 33'(cent_y) : dy;
    case (cnt[2:0])
      3'd0: begin mul_a = 33'(cell_xx); mul_b = va; end
      3'd1: begin mul_a = 33'(cell_xy); mul_b = vb; end
      3'd2: begin mul_a = 33'(cell_yx); mul_b = va; end
      3'd3: begin mul_a = 33'(cell_yy); mul_b = vb; end
      3'd5: begin mul_a = 33'(rx); mul_b = 33'(rx); end
      3'd6: begin mul_a = 33'(ry); mul_b = 33'(ry); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    logic signed [66:0] s;
    logic signed [50:0] sh;
    s = 67'(p_hold) + 67'(prod);
    sh = 51'(s >>> 16);
    if (sh > 51'sd2147483647) dot_sat = 32'sh7FFFFFFF;
    else if (sh < -51'sd2147483648) dot_sat = 32'sh80000000;
    else dot_sat = 32'(sh);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      center_pass <= 1'b0;
    end else if (state == rcps_pkg::S_PREP) begin
      center_pass <= 1'b1;
    end else if (state == rcps_pkg::S_READ) begin
      center_pass <= 1'b0;
    end
    if (state == rcps_pkg::S_PREP) idx <= '0;
    else if (state == rcps_pkg::S_EMIT) idx <= idx + AW'(1);
    if (state == rcps_pkg::S_DIFF) begin
      dx <= 33'(signed'(rd_data[63:32])) - 33'(cent_x);
      dy <= 33'(signed'(rd_data[31:0])) - 33'(cent_y);
    end
    if (state == rcps_pkg::S_MUL) begin
      case (cnt[2:0])
        3'd1, 3'd3, 3'd6: p_hold <= prod;
        3'd2: if (center_pass) tcx <= dot_sat; else rx <= dot_sat;
        3'd4: if (center_pass) tcy <= dot_sat; else ry <= dot_sat;
        default: ;
      endcase
    end
  end

  // radius and angle, one bit / one rotation per cycle
  logic [35:0] sq_rp, sq_t;
  logic signed [XW-1:0] xs, ys;
  assign sq_rp = {sq_r, sq_v[63:62]};
  assign sq_t = {2'b00, sq_q, 2'b01};
  assign xs = cx_c >>> cnt[4:0];
  assign ys = cy_c >>> cnt[4:0];

  always_ff @(posedge clk) begin
    if (state == rcps_pkg::S_MUL && !center_pass && cnt == 6'd7) begin
      sq_v <= 64'(p_hold) + 64'(prod);
      sq_r <= '0;
      sq_q <= '0;
      spec <= (ry == 0) || (rx == 0);
      if (ry == 0) spec_val <= rx[31] ? rcps_pkg::ANGLE_HALF : rcps_pkg::ANGLE_ZERO;
      else spec_val <= ry[31] ? rcps_pkg::ANGLE_3QUARTER : rcps_pkg::ANGLE_QUARTER;
      if (rx[31]) begin
        cx_c <= -XW'(rx);
        cy_c <= -XW'(ry);
        z <= rcps_pkg::ANGLE_HALF;
      end else begin
        cx_c <= XW'(rx);
        cy_c <= XW'(ry);
        z <= rcps_pkg::ANGLE_ZERO;
      end
    end else if (state == rcps_pkg::S_ITER) begin
      sq_v <= {sq_v[61:0], 2'b00};
      if (sq_rp >= sq_t) begin
        sq_r <= 34'(sq_rp - sq_t);
        sq_q <= {sq_q[30:0], 1'b1};
      end else begin
        sq_r <= 34'(sq_rp);
        sq_q <= {sq_q[30:0], 1'b0};
      end
      if (!cy_c[XW-1]) begin
        cx_c <= cx_c + ys;
        cy_c <= cy_c - xs;
        z <= z + rcps_pkg::atan_turn(cnt[4:0]);
      end else begin
        cx_c <= cx_c - ys;
        cy_c <= cy_c + xs;
        z <= z - rcps_pkg::atan_turn(cnt[4:0]);
      end
    end
  end

  always_comb begin
    result.node_index = 6'(idx);
    result.rel_x = rx;
    result.rel_y = ry;
    result.radius = sq_q;
    result.polar_angle = spec ? spec_val : z;
    result.center_x = tcx;
    result.center_y = tcy;
    result.is_last_result = last_node;
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("result strobe held two cycles");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.is_last_result) |=> (!busy && count == '0))
    else $error("run did not end after last result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NODES)) else $error("node count beyond store depth");
  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == rcps_pkg::S_PREP) |-> (count != '0))
    else $error("run started with no nodes");
`endif

endmodule
